>>> hw/rtl/twbc_pkg.sv
`default_nettype none

package twbc_pkg;

    localparam int ADDR_W = 16;
    localparam int DEF_CACHE_BYTES = 4096;
    localparam int DEF_LINE_BYTES = 64;
    localparam int DEF_MEM_BYTES = 65536;

    // byte steps of one access, and the largest byte count
    localparam int ACC_STEPS = 4;
    localparam logic [2:0] MAX_COUNT = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [15:0] address;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        was_hit;
        logic        wrote_back;
        logic        crosses_line;
        logic [63:0] hit_total;
        logic [63:0] access_total;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic resolve;
        logic clear;
        logic wb;
        logic fill;
        logic access;
        logic finish;
        logic step_rst;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic need_wb;
        logic step_end;
    } t_stat;

endpackage

`default_nettype wire

>>> hw/rtl/twbc_ctrl.sv
`default_nettype none

module twbc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_stall,
    input  wire twbc_pkg::t_stat i_stat,
    output twbc_pkg::t_cmd      o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import twbc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.step_end) begin
                    o_cmd.step_rst = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.resolve = 1'b1;
                if (i_stat.hit) n_state = ST_ACC;
                else if (i_stat.need_wb) n_state = ST_WB;
                else n_state = ST_FILL;
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                if (i_stat.step_end) begin
                    o_cmd.step_rst = 1'b1;
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.step_end) begin
                    o_cmd.step_rst = 1'b1;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.access = 1'b1;
                if (i_stat.step_end) begin
                    o_cmd.step_rst = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.finish | (r_out_valid & i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> hw/rtl/twbc_dp.sv
`default_nettype none

module twbc_dp #(
    parameter int CACHE_BYTES = twbc_pkg::DEF_CACHE_BYTES,
    parameter int LINE_BYTES  = twbc_pkg::DEF_LINE_BYTES,
    parameter int MEM_BYTES   = twbc_pkg::DEF_MEM_BYTES
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire twbc_pkg::t_in   i_item,
    input  wire twbc_pkg::t_cmd  i_cmd,
    output twbc_pkg::t_stat      o_stat,
    output twbc_pkg::t_out       o_item
);
    import twbc_pkg::*;

    localparam int SETS    = CACHE_BYTES / LINE_BYTES / 2;
    localparam int SLOTS   = SETS * 2;
    localparam int LINE_AW = $clog2(LINE_BYTES);
    localparam int SET_AW  = $clog2(SETS);
    localparam int SLOT_AW = SET_AW + 1;
    localparam int TAG_W   = ADDR_W - LINE_AW - SET_AW;
    localparam int MEM_AW  = $clog2(MEM_BYTES);
    localparam int STEP_W  = $clog2(MEM_BYTES + 1);
    localparam int LDEPTH  = SLOTS * LINE_BYTES;
    localparam int LA_W    = SLOT_AW + LINE_AW;

    // latched item
    logic              r_wr;
    logic [ADDR_W-1:0] r_addr;
    logic [2:0]        r_cnt;
    logic [31:0]       r_wdata;

    logic [LINE_AW-1:0] offset;
    logic [SET_AW-1:0]  set_idx, in_set;
    logic [TAG_W-1:0]   tag;
    assign offset  = r_addr[LINE_AW-1:0];
    assign set_idx = r_addr[LINE_AW +: SET_AW];
    assign tag     = r_addr[ADDR_W-1 -: TAG_W];
    assign in_set  = i_item.address[LINE_AW +: SET_AW];

    // tags, one row of both ways per set
    logic [2*TAG_W-1:0] r_tag_mem [SETS];
    logic [2*TAG_W-1:0] r_tag_row;
    logic [TAG_W-1:0]   tag0, tag1;
    assign tag0 = r_tag_row[TAG_W-1:0];
    assign tag1 = r_tag_row[2*TAG_W-1:TAG_W];

    logic [SLOTS-1:0] r_valid, r_dirty;
    logic [SETS-1:0]  r_recent;

    logic               v0, v1, hit0, hit1, hit, way;
    logic [SLOT_AW-1:0] slot_new;
    assign v0   = r_valid[{set_idx, 1'b0}];
    assign v1   = r_valid[{set_idx, 1'b1}];
    assign hit0 = v0 && (tag0 == tag);
    assign hit1 = v1 && (tag1 == tag);
    assign hit  = hit0 | hit1;
    always_comb begin
        if (hit0) way = 1'b0;
        else if (hit1) way = 1'b1;
        else if (!v1) way = 1'b1;    // empty set takes way 1 first
        else way = ~r_recent[set_idx];
    end
    assign slot_new = {set_idx, way};

    logic               r_hit, r_wb;
    logic [SLOT_AW-1:0] r_slot;
    logic [TAG_W-1:0]   r_vtag;

    // step counter for clear, line moves and byte steps
    logic [STEP_W-1:0] r_step, step_m1;
    assign step_m1 = r_step - STEP_W'(1);

    assign o_stat.hit      = hit;
    assign o_stat.need_wb  = !hit && r_valid[slot_new] && r_dirty[slot_new];
    assign o_stat.step_end =
        (i_cmd.clear && r_step == STEP_W'(MEM_BYTES - 1)) ||
        ((i_cmd.wb || i_cmd.fill) && r_step == STEP_W'(LINE_BYTES)) ||
        (i_cmd.access && r_step == STEP_W'(ACC_STEPS));

    // byte lane of the access
    logic [LINE_AW:0]   pos_full;
    logic [LINE_AW-1:0] pos;
    logic               lane_use;
    logic               crosses;
    assign pos_full = {1'b0, offset} + (LINE_AW + 1)'(r_step);
    assign pos      = pos_full[LINE_AW-1:0];
    assign lane_use = (r_step < STEP_W'(r_cnt)) && (pos_full < (LINE_AW + 1)'(LINE_BYTES));
    assign crosses  = ({1'b0, offset} + (LINE_AW + 1)'(r_cnt)) > (LINE_AW + 1)'(LINE_BYTES);

    // line moves
    logic                past_first;
    logic [LINE_AW-1:0]  mv_rd, mv_wr;
    logic [ADDR_W-1:0]   fill_rd_a, wb_wr_a;
    logic [ADDR_W+MEM_AW-1:0] fill_ext, wb_ext;
    assign past_first = r_step != '0;
    assign mv_rd      = r_step[LINE_AW-1:0];
    assign mv_wr      = step_m1[LINE_AW-1:0];
    assign fill_rd_a  = {tag, set_idx, mv_rd};
    assign wb_wr_a    = {r_vtag, set_idx, mv_wr};
    assign fill_ext   = (ADDR_W + MEM_AW)'(fill_rd_a);
    assign wb_ext     = (ADDR_W + MEM_AW)'(wb_wr_a);

    // line store
    logic [7:0]      r_line_mem [LDEPTH];
    logic [7:0]      r_line_q;
    logic            line_we;
    logic [LA_W-1:0] line_wa, line_ra;
    logic [7:0]      line_wd;

    // backing store
    logic [7:0]        r_back_mem [MEM_BYTES];
    logic [7:0]        r_back_q;
    logic              back_we;
    logic [MEM_AW-1:0] back_wa, back_ra;
    logic [7:0]        back_wd;

    always_comb begin
        line_we = 1'b0;
        line_wa = {r_slot, pos};
        line_wd = r_wdata[8*r_step[1:0] +: 8];
        line_ra = {r_slot, pos};
        if (i_cmd.fill) begin
            line_we = past_first;
            line_wa = {r_slot, mv_wr};
            line_wd = r_back_q;
        end else if (i_cmd.access) begin
            line_we = lane_use && r_wr;
        end
        if (i_cmd.wb) line_ra = {r_slot, mv_rd};

        back_we = 1'b0;
        back_wa = r_step[MEM_AW-1:0];
        back_wd = '0;
        if (i_cmd.wb) begin
            back_we = past_first;
            back_wa = wb_ext[MEM_AW-1:0];
            back_wd = r_line_q;
        end else if (i_cmd.clear) begin
            back_we = 1'b1;
        end
        back_ra = fill_ext[MEM_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (line_we) r_line_mem[line_wa] <= line_wd;
        r_line_q <= r_line_mem[line_ra];
    end

    always_ff @(posedge i_clk) begin
        if (back_we) r_back_mem[back_wa] <= back_wd;
        r_back_q <= r_back_mem[back_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_tag_row <= r_tag_mem[in_set];
        if (i_cmd.resolve && !hit) begin
            r_tag_mem[set_idx] <= way ? {tag, tag0} : {tag1, tag};
        end
    end

    // control state: marks, counters, step
    logic [63:0] r_hit_cnt, r_acc_cnt;
    logic        r_rd_en;
    logic [1:0]  r_rd_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_recent  <= '0;
            r_hit_cnt <= '0;
            r_acc_cnt <= '0;
            r_step    <= '0;
            r_rd_en   <= 1'b0;
        end else begin
            if (i_cmd.resolve) begin
                r_valid[slot_new]  <= 1'b1;
                r_dirty[slot_new]  <= r_wr | (hit & r_dirty[slot_new]);
                r_recent[set_idx]  <= way;
            end
            if (i_cmd.finish) begin
                r_acc_cnt <= r_acc_cnt + 64'd1;
                r_hit_cnt <= r_hit_cnt + 64'(r_hit);
            end
            if (i_cmd.step_rst) r_step <= '0;
            else if (i_cmd.clear | i_cmd.wb | i_cmd.fill | i_cmd.access)
                r_step <= r_step + STEP_W'(1);
            r_rd_en <= i_cmd.access && lane_use && !r_wr;
        end
    end

    // payload
    logic [31:0] r_rdata;
    t_out        r_out;

    always_ff @(posedge i_clk) begin
        r_rd_lane <= r_step[1:0];
        if (i_cmd.load) begin
            r_wr    <= i_item.opcode;
            r_addr  <= i_item.address;
            r_cnt   <= (i_item.byte_count > MAX_COUNT) ? MAX_COUNT : i_item.byte_count;
            r_wdata <= i_item.write_data;
            r_rdata <= '0;
        end else if (r_rd_en) begin
            r_rdata[8*r_rd_lane +: 8] <= r_line_q;
        end
        if (i_cmd.resolve) begin
            r_hit  <= hit;
            r_wb   <= o_stat.need_wb;
            r_slot <= slot_new;
            r_vtag <= way ? tag1 : tag0;
        end
        if (i_cmd.finish) begin
            r_out.read_data    <= r_rdata;
            r_out.was_hit      <= r_hit;
            r_out.wrote_back   <= r_wb;
            r_out.crosses_line <= crosses;
            r_out.hit_total    <= r_hit_cnt + 64'(r_hit);
            r_out.access_total <= r_acc_cnt + 64'd1;
        end
    end

    assign o_item = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/two_way_write_back_cache.sv
`default_nettype none

// two-way set-associative write-back cache (64-byte lines, 32 sets by default)
// with its own byte-wide backing store, one read or write of up to 4 bytes per
// item; a hit passes through accept, tag lookup, five byte steps on the
// byte-wide line store and result load; a miss adds the fill and, if the
// victim is dirty, the write-back before the byte steps, both memories moving
// one byte a cycle; the block takes no new item until the last one has left
// the result-load step, and a result held by the receiver keeps the next item
// waiting in the result-load step; after reset a clearing pass zeroes the
// backing store, during which no item is taken

module two_way_write_back_cache #(
    parameter int CACHE_BYTES = twbc_pkg::DEF_CACHE_BYTES,
    parameter int LINE_BYTES  = twbc_pkg::DEF_LINE_BYTES,
    parameter int MEM_BYTES   = twbc_pkg::DEF_MEM_BYTES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // item in
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire twbc_pkg::t_in i_in_item,
    // result out
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output twbc_pkg::t_out     o_out_item
);
    import twbc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: clear pass, lookup, write-back, fill, byte steps, result
    twbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // tags, marks, line and backing memories, counters, result register
    twbc_dp #(
        .CACHE_BYTES (CACHE_BYTES),
        .LINE_BYTES  (LINE_BYTES),
        .MEM_BYTES   (MEM_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_item  (o_out_item)
    );

    // one item at a time: an accepted item closes the input
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accept");

    // a hit never evicts
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.was_hit) |-> !o_out_item.wrote_back)
        else $error("write-back reported on a hit");

    // the sequencer never starts a line move on a hit
    a_move_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.resolve && stat.hit) |=> !cmd.wb && !cmd.fill)
        else $error("line move after a hit");

endmodule

`default_nettype wire
